// ===== rtl/core/imt_pkg.sv =====
// imt_pkg: shared types, constants and field layout of the imu motion tracker
// used by imt_isqrt and imu_motion_and_orientation_tracker_core; depends on nothing
`default_nettype none
package imt_pkg;

    // speed state width default
    localparam int SPEED_WIDTH_DEF = 40;

    // field widths
    localparam int ACC_W      = 16;
    localparam int ANG_W      = 13;
    localparam int DT_W       = 16;
    localparam int VEL_OUT_W  = 40;
    localparam int AMAG_W     = 16;
    localparam int VMAG_W     = 30;
    localparam int DB_W       = 15;
    localparam int THR_W      = 16;

    // stream widths, padded to bytes
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 256;

    // input field offsets
    localparam int IN_AX  = 0;
    localparam int IN_AY  = 16;
    localparam int IN_AZ  = 32;
    localparam int IN_HD  = 48;
    localparam int IN_RL  = 61;
    localparam int IN_PT  = 74;
    localparam int IN_DT  = 87;

    // output field offsets
    localparam int OUT_AX    = 0;
    localparam int OUT_AY    = 16;
    localparam int OUT_AZ    = 32;
    localparam int OUT_VX    = 48;
    localparam int OUT_VY    = 88;
    localparam int OUT_VZ    = 128;
    localparam int OUT_AMAG  = 168;
    localparam int OUT_VMAG  = 184;
    localparam int OUT_SHOCK = 214;
    localparam int OUT_HD    = 215;
    localparam int OUT_RL    = 228;
    localparam int OUT_PT    = 241;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TARE_X      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARE_Y      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARE_Z      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_HEADING = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_ROLL    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_PITCH   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOCK_THR   = 4'd7;

    localparam logic [DB_W-1:0]  DEAD_BAND_RST = 15'd15;
    localparam logic [THR_W-1:0] SHOCK_THR_RST = 16'd800;

    // arithmetic constants
    localparam logic [15:0] FRIC_Q15     = 16'd32113;  // 0.98 in q15
    localparam int          STOP_SPEED   = 5000;       // 0.05 m/s
    localparam logic [14:0] FULL_TURN    = 15'd5760;
    localparam logic [14:0] HALF_TURN    = 15'd2880;
    localparam logic [14:0] HEADING_BIAS = 15'd11520;  // two full turns

    // shared multiplier
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // shared square root unit
    localparam int SQ_IN_W   = 64;
    localparam int SQ_ROOT_W = 32;
    localparam int SQ_CNT_W  = 5;
    localparam logic [SQ_CNT_W-1:0] ACC_SQRT_TOP = 5'd15;  // radicand below 2^32
    localparam logic [SQ_CNT_W-1:0] VEL_SQRT_TOP = 5'd30;  // radicand below 2^62

    typedef struct packed {
        logic                start;
        logic [SQ_CNT_W-1:0] top;    // first bit pair index
    } t_sqrt_ctl;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AMUL,
        ST_FLO,
        ST_FHI,
        ST_FSUM,
        ST_UPD,
        ST_ASQ,
        ST_TSQ,
        ST_SHK,
        ST_VSQ,
        ST_VACC,
        ST_AWAIT,
        ST_VSQRT,
        ST_VWAIT,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/core/imt_isqrt.sv =====
// imt_isqrt: iterative floor square root, one result bit per cycle
// depends on imt_pkg for widths and the control struct
`default_nettype none
module imt_isqrt
    import imt_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_sqrt_ctl            i_ctl,
    input  wire logic [SQ_IN_W-1:0]   i_radicand,
    output logic                      o_busy,
    output logic [SQ_ROOT_W-1:0]      o_root
);

    logic [SQ_IN_W-1:0]  r_n;
    logic [SQ_IN_W-1:0]  r_r;
    logic [SQ_CNT_W-1:0] r_cnt;
    logic                r_busy;

    logic [SQ_IN_W-1:0]  sq_bit;
    logic [SQ_IN_W-1:0]  sq_trial;
    logic                sq_fit;

    assign sq_bit   = SQ_IN_W'(1) << {r_cnt, 1'b0};
    assign sq_trial = r_r + sq_bit;
    assign sq_fit   = r_n >= sq_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_ctl.top;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_n <= i_radicand;
            r_r <= '0;
        end else if (r_busy) begin
            if (sq_fit) begin
                r_n <= r_n - sq_trial;
                r_r <= (r_r >> 1) + sq_bit;
            end else begin
                r_r <= r_r >> 1;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_r[SQ_ROOT_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/imu_motion_and_orientation_tracker_core.sv =====
// imu_motion_and_orientation_tracker_core: top level of the imu motion tracker
// depends on imt_pkg and imt_isqrt
//
// usage
//   s_axis carries one imu sample per transaction (three raw accelerations, heading,
//   roll, pitch, dt). m_axis carries one result per sample: tared accelerations,
//   the three speeds after update, both magnitudes, the shock flag and the
//   relative angles. the cfg channel writes one register per transaction and is
//   always ready; write it only while no sample is in flight.
//   s_axis_tready stays low from the acceptance of a sample until its result is
//   loaded into the output register, so one sample is worked on at a time. the
//   time goes to the shared 16x32 multiplier (the speed update of each axis, then
//   the squares) and to the shared square root unit, which runs 16 iterations for
//   the acceleration magnitude and 31 for the speed magnitude.
//   the result sits in an output register, so the next sample is accepted while
//   a result still waits; if the receiver stalls longer, the following sample
//   finishes and holds in its last step until the register frees up.
//   reset (synchronous, active low) clears the speeds to zero, loads the register
//   defaults and drops m_axis_tvalid.
`default_nettype none
module imu_motion_and_orientation_tracker_core
    import imt_pkg::*;
#(
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF   // 32 .. 48
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // sample in: raw_ax, raw_ay, raw_az, heading_in, roll_in, pitch_in, dt_ms, pad
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // result out: acc_x, acc_y, acc_z, vel_x, vel_y, vel_z, acc_magnitude,
    // vel_magnitude, shock, rel_heading, rel_roll, rel_pitch, pad
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // register writes
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int SW = SPEED_WIDTH;

    // configuration registers
    logic signed [ACC_W-1:0] r_tare [3];
    logic [ANG_W-1:0]        r_ref_hd;
    logic signed [ANG_W-1:0] r_ref_rl;
    logic signed [ANG_W-1:0] r_ref_pt;
    logic [DB_W-1:0]         r_dead_band;
    logic [THR_W-1:0]        r_shock_thr;

    // sequencer
    t_state      r_state, n_state;
    logic [1:0]  r_k, n_k;      // axis under work
    logic        r_j, n_j;      // low/high half of a speed square

    // sample and state
    logic signed [ACC_W-1:0] r_acc [3];
    logic signed [SW-1:0]    r_speed [3];
    logic [DT_W-1:0]         r_dt;
    logic [ANG_W-1:0]        r_rel_hd;
    logic [ANG_W-1:0]        r_rel_rl;
    logic [ANG_W-1:0]        r_rel_pt;

    // datapath
    logic [MUL_P_W-1:0]   r_prod;
    logic [31:0]          r_adt;
    logic [SQ_IN_W-1:0]   r_sum;
    logic                 r_shock;
    logic                 r_vbig;
    logic [AMAG_W-1:0]    r_amag;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;

    // output register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   out_load;

    // square root unit
    t_sqrt_ctl              sqrt_ctl;
    logic                   sqrt_busy;
    logic [SQ_ROOT_W-1:0]   sqrt_root;

    logic in_acc;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;

    // ---------------- register writes ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tare[0]   <= '0;
            r_tare[1]   <= '0;
            r_tare[2]   <= '0;
            r_ref_hd    <= '0;
            r_ref_rl    <= '0;
            r_ref_pt    <= '0;
            r_dead_band <= DEAD_BAND_RST;
            r_shock_thr <= SHOCK_THR_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TARE_X:      r_tare[0]   <= i_cfg_data;
                CFG_TARE_Y:      r_tare[1]   <= i_cfg_data;
                CFG_TARE_Z:      r_tare[2]   <= i_cfg_data;
                CFG_REF_HEADING: r_ref_hd    <= i_cfg_data[ANG_W-1:0];
                CFG_REF_ROLL:    r_ref_rl    <= i_cfg_data[ANG_W-1:0];
                CFG_REF_PITCH:   r_ref_pt    <= i_cfg_data[ANG_W-1:0];
                CFG_DEAD_BAND:   r_dead_band <= i_cfg_data[DB_W-1:0];
                CFG_SHOCK_THR:   r_shock_thr <= i_cfg_data;
                default:         ;   // unknown index, write dropped
            endcase
        end
    end

    // ---------------- input stage: tare and angle wrap ----------------
    logic signed [ACC_W-1:0] raw [3];
    logic signed [ACC_W:0]   tdiff [3];
    logic signed [ACC_W-1:0] tared [3];

    assign raw[0] = s_axis_tdata[IN_AX +: ACC_W];
    assign raw[1] = s_axis_tdata[IN_AY +: ACC_W];
    assign raw[2] = s_axis_tdata[IN_AZ +: ACC_W];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            tdiff[i] = (ACC_W+1)'(raw[i]) - (ACC_W+1)'(r_tare[i]);
            // saturate to 16 bits when the two top bits disagree
            if (tdiff[i][ACC_W] != tdiff[i][ACC_W-1]) begin
                tared[i] = tdiff[i][ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                           : {1'b0, {(ACC_W-1){1'b1}}};
            end else begin
                tared[i] = tdiff[i][ACC_W-1:0];
            end
        end
    end

    // heading: bias by two turns so the difference is positive, then at most
    // three compare-subtract steps bring it into one turn
    logic [14:0] hd_w [4];
    always_comb begin
        hd_w[0] = 15'(s_axis_tdata[IN_HD +: ANG_W]) + HEADING_BIAS - 15'(r_ref_hd);
        for (int i = 1; i < 4; i++) begin
            hd_w[i] = (hd_w[i-1] >= FULL_TURN) ? hd_w[i-1] - FULL_TURN : hd_w[i-1];
        end
    end

    // roll and pitch: one correction each way
    function automatic logic [ANG_W-1:0] wrap_once(input logic signed [ANG_W-1:0] a,
                                                   input logic signed [ANG_W-1:0] b);
        logic signed [14:0] d;
        d = 15'(a) - 15'(b);
        if (d < -$signed(HALF_TURN)) d = d + $signed(FULL_TURN);
        if (d > $signed(HALF_TURN))  d = d - $signed(FULL_TURN);
        return d[ANG_W-1:0];
    endfunction

    // ---------------- current axis values ----------------
    logic signed [ACC_W-1:0] cur_a;
    logic signed [SW-1:0]    cur_v;
    logic [ACC_W-1:0]        a_mag;
    logic [SW-1:0]           v_mag;
    logic [63:0]             v_mag64;
    logic                    moving;
    logic signed [SW:0]      move_sum;
    logic signed [SW-1:0]    move_v;
    logic [SW-1:0]           fric_m;
    logic [SW-1:0]           fric_z;
    logic signed [SW-1:0]    fric_v;
    logic signed [SW-1:0]    upd_v;
    logic [29:0]             v_sq;

    assign cur_a   = r_acc[r_k];
    assign cur_v   = r_speed[r_k];
    assign a_mag   = cur_a[ACC_W-1] ? ACC_W'(-cur_a) : cur_a;
    assign v_mag   = cur_v[SW-1] ? SW'(-cur_v) : cur_v;
    assign v_mag64 = 64'(v_mag);
    assign moving  = a_mag > ACC_W'(r_dead_band);
    assign v_sq    = v_mag[29:0];

    always_comb begin
        // moving: add a*dt, saturate to the speed range
        if (cur_a[ACC_W-1]) begin
            move_sum = (SW+1)'(cur_v) - (SW+1)'(r_adt);
        end else begin
            move_sum = (SW+1)'(cur_v) + (SW+1)'(r_adt);
        end
        if (move_sum[SW] != move_sum[SW-1]) begin
            move_v = move_sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            move_v = move_sum[SW-1:0];
        end
        // still: magnitude times 0.98, truncated, zero below stop speed
        fric_m = r_sum[SW+14:15];
        fric_z = (fric_m < SW'(STOP_SPEED)) ? '0 : fric_m;
        fric_v = cur_v[SW-1] ? SW'(-fric_z) : fric_z;
        upd_v  = moving ? move_v : fric_v;
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_j     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_j     <= n_j;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_k            = r_k;
        n_j            = r_j;
        mul_a          = '0;
        mul_b          = '0;
        sqrt_ctl.start = 1'b0;
        sqrt_ctl.top   = ACC_SQRT_TOP;
        out_load       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_k = '0;
                if (in_acc) n_state = ST_AMUL;
            end
            ST_AMUL: begin
                mul_a   = MUL_A_W'(a_mag);
                mul_b   = r_dt;
                n_state = ST_FLO;
            end
            ST_FLO: begin
                mul_a   = v_mag64[31:0];
                mul_b   = FRIC_Q15;
                n_state = ST_FHI;
            end
            ST_FHI: begin
                mul_a   = MUL_A_W'(v_mag64[47:32]);
                mul_b   = FRIC_Q15;
                n_state = ST_FSUM;
            end
            ST_FSUM: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (r_k == 2'd2) begin
                    n_k     = '0;
                    n_state = ST_ASQ;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_AMUL;
                end
            end
            ST_ASQ: begin
                mul_a = MUL_A_W'(a_mag);
                mul_b = a_mag;
                if (r_k == 2'd2) begin
                    n_k     = '0;
                    n_state = ST_TSQ;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_TSQ: begin
                mul_a   = MUL_A_W'(r_shock_thr);
                mul_b   = r_shock_thr;
                n_state = ST_SHK;
            end
            ST_SHK: begin
                sqrt_ctl.start = 1'b1;
                sqrt_ctl.top   = ACC_SQRT_TOP;
                n_k            = '0;
                n_j            = 1'b0;
                n_state        = ST_VSQ;
            end
            ST_VSQ: begin
                // |v|^2 = |v|*low16 + (|v|*high14 << 16)
                mul_a = MUL_A_W'(v_sq);
                mul_b = r_j ? MUL_B_W'(v_sq[29:16]) : v_sq[15:0];
                n_j   = ~r_j;
                if (r_j) begin
                    if (r_k == 2'd2) begin
                        n_k     = '0;
                        n_state = ST_VACC;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            ST_VACC: begin
                n_state = ST_AWAIT;
            end
            ST_AWAIT: begin
                if (!sqrt_busy) n_state = ST_VSQRT;
            end
            ST_VSQRT: begin
                sqrt_ctl.start = 1'b1;
                sqrt_ctl.top   = VEL_SQRT_TOP;
                n_state        = ST_VWAIT;
            end
            ST_VWAIT: begin
                if (!sqrt_busy) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------- speed state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed[0] <= '0;
            r_speed[1] <= '0;
            r_speed[2] <= '0;
        end else if (r_state == ST_UPD) begin
            r_speed[r_k] <= upd_v;
        end
    end

    // ---------------- shared multiplier and accumulator ----------------
    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_acc[0] <= tared[0];
                    r_acc[1] <= tared[1];
                    r_acc[2] <= tared[2];
                    r_dt     <= s_axis_tdata[IN_DT +: DT_W];
                    r_rel_hd <= hd_w[3][ANG_W-1:0];
                    r_rel_rl <= wrap_once(s_axis_tdata[IN_RL +: ANG_W], r_ref_rl);
                    r_rel_pt <= wrap_once(s_axis_tdata[IN_PT +: ANG_W], r_ref_pt);
                end
            end
            ST_FLO:  r_adt <= r_prod[31:0];
            ST_FHI:  r_sum <= SQ_IN_W'(r_prod);
            ST_FSUM: r_sum <= r_sum + (SQ_IN_W'(r_prod) << 32);
            ST_ASQ: begin
                if (r_k == 2'd0) begin
                    r_sum <= '0;
                end else begin
                    r_sum <= r_sum + SQ_IN_W'(r_prod);
                end
            end
            ST_TSQ:  r_sum <= r_sum + SQ_IN_W'(r_prod);
            ST_SHK: begin
                // the sum of squares exceeds threshold squared
                r_shock <= r_sum > SQ_IN_W'(r_prod);
                r_vbig  <= 1'b0;
            end
            ST_VSQ: begin
                if ((v_mag >> 30) != '0) r_vbig <= 1'b1;
                if (r_k == 2'd0 && !r_j) begin
                    r_sum <= '0;
                end else if (!r_j) begin
                    r_sum <= r_sum + (SQ_IN_W'(r_prod) << 16);
                end else begin
                    r_sum <= r_sum + SQ_IN_W'(r_prod);
                end
            end
            ST_VACC: r_sum <= r_sum + (SQ_IN_W'(r_prod) << 16);
            ST_AWAIT: begin
                if (!sqrt_busy) r_amag <= sqrt_root[AMAG_W-1:0];
            end
            default: ;
        endcase
    end

    imt_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (sqrt_ctl),
        .i_radicand (r_sum),
        .o_busy     (sqrt_busy),
        .o_root     (sqrt_root)
    );

    // ---------------- output register ----------------
    logic [63:0]       sp_ext [3];
    logic [VMAG_W-1:0] vmag_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sp_ext[i] = {{(64-SW){r_speed[i][SW-1]}}, r_speed[i]};
        end
        // saturate when an axis is too fast or the root reaches 2^30
        if (r_vbig || sqrt_root[SQ_ROOT_W-1:VMAG_W] != '0) begin
            vmag_out = '1;
        end else begin
            vmag_out = sqrt_root[VMAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data                          <= '0;
            r_out_data[OUT_AX +: ACC_W]         <= r_acc[0];
            r_out_data[OUT_AY +: ACC_W]         <= r_acc[1];
            r_out_data[OUT_AZ +: ACC_W]         <= r_acc[2];
            r_out_data[OUT_VX +: VEL_OUT_W]     <= sp_ext[0][VEL_OUT_W-1:0];
            r_out_data[OUT_VY +: VEL_OUT_W]     <= sp_ext[1][VEL_OUT_W-1:0];
            r_out_data[OUT_VZ +: VEL_OUT_W]     <= sp_ext[2][VEL_OUT_W-1:0];
            r_out_data[OUT_AMAG +: AMAG_W]      <= r_amag;
            r_out_data[OUT_VMAG +: VMAG_W]      <= vmag_out;
            r_out_data[OUT_SHOCK]               <= r_shock;
            r_out_data[OUT_HD +: ANG_W]         <= r_rel_hd;
            r_out_data[OUT_RL +: ANG_W]         <= r_rel_rl;
            r_out_data[OUT_PT +: ANG_W]         <= r_rel_pt;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ---------------- assertions ----------------
    // the square root unit is never restarted mid-run
    a_sqrt_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_ctl.start |-> !sqrt_busy)
        else $error("square root started while busy");

    // after a sample transaction the block stays busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_axis_tready)
        else $error("ready right after an accepted sample");

    // a raised shock flag means the reported magnitude reaches the threshold
    a_shock_vs_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[OUT_SHOCK])
            |-> (m_axis_tdata[OUT_AMAG +: AMAG_W] >= r_shock_thr))
        else $error("shock flag without matching magnitude");

endmodule
`default_nettype wire
